FILE: rtl/core/mtf_pkg.sv
`timescale 1ns / 1ps

package mtf_pkg;

    localparam int ALPHABET_SIZE = 256;
    localparam int DATA_W        = 8;
    localparam int IDX_W         = $clog2(ALPHABET_SIZE);

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    typedef struct packed {
        logic init_wr;
        logic load;
        logic scan;
        logic front;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic init_last;
        logic enc_miss;
        logic hit;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/core/mtf_ram.sv
`timescale 1ns / 1ps

module mtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/mtf_datapath.sv
`timescale 1ns / 1ps

module mtf_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mtf_pkg::t_dp_cmd           i_cmd,
    output mtf_pkg::t_dp_sts           o_sts,
    input  logic [mtf_pkg::DATA_W-1:0] i_data_in,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    input  logic                       i_stall,
    output logic                       o_valid,
    output logic [mtf_pkg::DATA_W-1:0] o_data_out
);
    import mtf_pkg::*;

    logic              r_mode;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic              r_cmp_vld;
    logic [DATA_W-1:0] r_key;
    logic [DATA_W-1:0] r_prev;
    logic [DATA_W-1:0] r_sym;
    logic [DATA_W-1:0] r_res;
    logic [DATA_W-1:0] r_out;
    logic              r_out_vld;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;
    logic              key_over;
    logic              hit;

    mtf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_order (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign key_over = ({1'b0, i_data_in} >= (DATA_W + 1)'(ALPHABET_SIZE));

    assign hit = r_cmp_vld &&
                 ((r_mode == MODE_ENC) ? (ram_rdata == r_key)
                                       : (DATA_W'(r_cmp_idx) == r_key));

    // shift each scanned entry down by one until the match, then the symbol goes to 0
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cmp_idx;
        ram_wdata = r_prev;
        if (i_cmd.init_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_rd_idx;
            ram_wdata = DATA_W'(r_rd_idx);
        end else if (i_cmd.front) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = r_sym;
        end else if (i_cmd.scan && r_cmp_vld && (r_cmp_idx != '0)) begin
            ram_we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_ENC;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (i_cmd.init_wr) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
            end else if (i_cmd.load) begin
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_idx  <= r_rd_idx + IDX_W'(1);
                r_cmp_vld <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (r_mode == MODE_DEC && key_over) begin
                r_key <= DATA_W'(ALPHABET_SIZE - 1);
            end else begin
                r_key <= i_data_in;
            end
            r_res <= DATA_W'(ALPHABET_SIZE);
        end
        if (i_cmd.scan) begin
            r_cmp_idx <= r_rd_idx;
            if (r_cmp_vld) begin
                r_prev <= ram_rdata;
            end
            if (hit) begin
                r_sym <= ram_rdata;
                r_res <= (r_mode == MODE_ENC) ? DATA_W'(r_cmp_idx) : ram_rdata;
            end
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_sts.init_last = (r_rd_idx == IDX_W'(ALPHABET_SIZE - 1));
    assign o_sts.enc_miss  = (r_mode == MODE_ENC) && key_over;
    assign o_sts.hit       = hit;
    assign o_sts.out_free  = !r_out_vld || !i_stall;

    assign o_valid    = r_out_vld;
    assign o_data_out = r_out;

endmodule

FILE: rtl/core/mtf_ctrl.sv
`timescale 1ns / 1ps

module mtf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  mtf_pkg::t_dp_sts i_sts,
    output mtf_pkg::t_dp_cmd o_cmd
);
    import mtf_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_FRONT,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_sts.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.enc_miss ? S_HOLD : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_FRONT;
                end
            end
            S_FRONT: begin
                o_cmd.front = 1'b1;
                n_state     = S_HOLD;
            end
            S_HOLD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

FILE: rtl/core/move_to_front_codec_unit.sv
// Move-to-front codec over 256 byte symbols. Mode 0 encodes a symbol to its
// position in the current order, mode 1 decodes a position to its symbol;
// either way the symbol then moves to the front. The order lives in one
// 256x8 RAM with one read and one write port, walked from the front one entry
// per cycle while entries are shifted back in the same pass. Each item is
// scanned to its match and moved to the front, then its result is loaded
// onto o_valid, later only while i_stall holds an earlier result, and only
// then is the next transfer taken. After reset the RAM is filled with the
// identity order, all 256 entries, while o_stall stays high. The user must
// write the mode register only while idle; the block does not check this.
`timescale 1ns / 1ps

module move_to_front_codec_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [mtf_pkg::DATA_W-1:0] i_data_in,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [mtf_pkg::DATA_W-1:0] o_data_out
);
    import mtf_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    mtf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    mtf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_data_in   (i_data_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_data_out  (o_data_out)
    );

endmodule
